// ===== rtl/bir_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear image resize package
// Shared constants and codes for the bilinear image resize block.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

   localparam int MAX_IN_DIM_DEF  = 512;
   localparam int MAX_OUT_DIM_DEF = 1024;
   localparam int FRAC_BITS_DEF   = 8;

   localparam int CH_W            = 8;
   localparam int BYTES_PER_PIXEL = 3;
   localparam int PIX_W           = BYTES_PER_PIXEL * CH_W;

   localparam int IN_DIM_W  = 10;
   localparam int OUT_DIM_W = 11;
   localparam int COORD_W   = 10;

   localparam logic [IN_DIM_W-1:0]  IN_DIM_RST  = 10'd512;
   localparam logic [OUT_DIM_W-1:0] OUT_DIM_RST = 11'd650;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic CSR_IN_DIM  = 1'b0;
   localparam logic CSR_OUT_DIM = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/bilinear_image_resize.sv =====
// ----------------------------------------------------------------------------
// Bilinear image resize
// Loads a square RGB image and returns bilinearly resized output pixels.
// ----------------------------------------------------------------------------
// The block takes one transfer per cycle and returns one result per cycle for
// a stream of queries while the output register is not stalled. A pipelined
// divider maps each output coordinate to a source position, one quotient bit
// per stage. The image store is split in four banks by row and column parity,
// so the four neighbours of a pixel are read in the same cycle. Loads and
// queries travel the same pipeline in order, so a query always sees every
// load accepted before it. The store needs no clearing pass; reading a pixel
// that was never loaded gives undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_resize #(
   parameter int MAX_IN_DIM  = bir_pkg::MAX_IN_DIM_DEF,
   parameter int MAX_OUT_DIM = bir_pkg::MAX_OUT_DIM_DEF,
   parameter int FRAC_BITS   = bir_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // row[9:0], col[19:10], red_in[27:20], green_in[35:28], blue_in[43:36]
   input  wire logic [47:0] req_tdata,
   // mode[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_row[9:0], out_col[19:10], red_out[27:20], green_out[35:28],
   // blue_out[43:36]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   localparam int CW    = bir_pkg::COORD_W;
   localparam int CHW   = bir_pkg::CH_W;
   localparam int PW    = bir_pkg::PIX_W;
   localparam int IW    = $clog2(MAX_IN_DIM);
   localparam int HW    = (IW > 1) ? IW - 1 : 1;
   localparam int AW    = 2 * HW;
   localparam int DEPTH = 1 << AW;
   localparam int NW    = IW + 1;
   localparam int DDW   = $clog2(MAX_OUT_DIM) + 1;
   localparam int PRW   = CW + NW;
   localparam int DVW   = PRW + FRAC_BITS;
   localparam int QW    = IW + FRAC_BITS;
   localparam int WW    = FRAC_BITS + 1;
   localparam int W2    = 2 * FRAC_BITS + 1;
   localparam int MW    = W2 + CHW;
   localparam int SW    = MW + 2;

   // ---------------- configuration ----------------
   logic [bir_pkg::IN_DIM_W-1:0]  in_dim_ff;
   logic [bir_pkg::OUT_DIM_W-1:0] out_dim_ff;
   logic [NW-1:0]                 n_s;
   logic [DDW-1:0]                d_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_dim_ff  <= bir_pkg::IN_DIM_RST;
         out_dim_ff <= bir_pkg::OUT_DIM_RST;
      end else if (csr_we) begin
         case (csr_index)
            bir_pkg::CSR_IN_DIM:  in_dim_ff  <= csr_wdata[bir_pkg::IN_DIM_W-1:0];
            bir_pkg::CSR_OUT_DIM: out_dim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(in_dim_ff) < 32'd2)              n_s = NW'(2);
      else if (32'(in_dim_ff) > MAX_IN_DIM)    n_s = NW'(MAX_IN_DIM);
      else                                     n_s = NW'(in_dim_ff);
      if (32'(out_dim_ff) < 32'd2)             d_s = DDW'(2);
      else if (32'(out_dim_ff) > MAX_OUT_DIM)  d_s = DDW'(MAX_OUT_DIM);
      else                                     d_s = DDW'(out_dim_ff);
   end

   // ---------------- flow control ----------------
   logic rsp_vld_ff;
   logic en;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- input stage: scale by in_dim ----------------
   logic [CW-1:0] req_row;
   logic [CW-1:0] req_col;
   logic [PW-1:0] req_pix;

   assign req_row = req_tdata[9:0];
   assign req_col = req_tdata[19:10];
   assign req_pix = {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36]};

   logic           s0_vld_ff, s0_qry_ff, s0_ld_ff, s0_lr_ff, s0_lc_ff;
   logic [CW-1:0]  s0_row_ff, s0_col_ff;
   logic [PW-1:0]  s0_pix_ff;
   logic [PRW-1:0] s0_pr_ff, s0_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_qry_ff <= (req_tuser[0] == bir_pkg::MODE_QUERY)
                      && (32'(req_row) < 32'(d_s)) && (32'(req_col) < 32'(d_s));
         s0_ld_ff  <= (req_tuser[0] == bir_pkg::MODE_LOAD)
                      && (32'(req_row) < MAX_IN_DIM) && (32'(req_col) < MAX_IN_DIM);
         s0_lr_ff  <= 32'(req_row) == 32'(d_s) - 32'd1;
         s0_lc_ff  <= 32'(req_col) == 32'(d_s) - 32'd1;
         s0_row_ff <= req_row;
         s0_col_ff <= req_col;
         s0_pix_ff <= req_pix;
         s0_pr_ff  <= PRW'(req_row) * PRW'(n_s);
         s0_pc_ff  <= PRW'(req_col) * PRW'(n_s);
      end
   end

   // ---------------- source position divide ----------------
   logic [QW-1:0] q_r, q_c;

   bir_div #(.DVW(DVW), .DSW(DDW), .QW(QW)) u_div_row (
      .clock    (clock),
      .en       (en),
      .dividend ({s0_pr_ff, FRAC_BITS'(0)}),
      .divisor  (d_s),
      .quotient (q_r)
   );

   bir_div #(.DVW(DVW), .DSW(DDW), .QW(QW)) u_div_col (
      .clock    (clock),
      .en       (en),
      .dividend ({s0_pc_ff, FRAC_BITS'(0)}),
      .divisor  (d_s),
      .quotient (q_c)
   );

   logic          dl_vld_ff [QW];
   logic          dl_qry_ff [QW];
   logic          dl_ld_ff  [QW];
   logic          dl_lr_ff  [QW];
   logic          dl_lc_ff  [QW];
   logic [CW-1:0] dl_row_ff [QW];
   logic [CW-1:0] dl_col_ff [QW];
   logic [PW-1:0] dl_pix_ff [QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QW; k++) dl_vld_ff[k] <= 1'b0;
      end else if (en) begin
         dl_vld_ff[0] <= s0_vld_ff;
         for (int k = 1; k < QW; k++) dl_vld_ff[k] <= dl_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_qry_ff[0] <= s0_qry_ff;
         dl_ld_ff[0]  <= s0_ld_ff;
         dl_lr_ff[0]  <= s0_lr_ff;
         dl_lc_ff[0]  <= s0_lc_ff;
         dl_row_ff[0] <= s0_row_ff;
         dl_col_ff[0] <= s0_col_ff;
         dl_pix_ff[0] <= s0_pix_ff;
         for (int k = 1; k < QW; k++) begin
            dl_qry_ff[k] <= dl_qry_ff[k-1];
            dl_ld_ff[k]  <= dl_ld_ff[k-1];
            dl_lr_ff[k]  <= dl_lr_ff[k-1];
            dl_lc_ff[k]  <= dl_lc_ff[k-1];
            dl_row_ff[k] <= dl_row_ff[k-1];
            dl_col_ff[k] <= dl_col_ff[k-1];
            dl_pix_ff[k] <= dl_pix_ff[k-1];
         end
      end
   end

   // ---------------- map to neighbours and weights ----------------
   logic [IW-1:0]        nm1;
   logic [IW-1:0]        r0_in, r1_in, c0_in, c1_in;
   logic [FRAC_BITS-1:0] a_in, b_in;

   assign nm1 = IW'(n_s - NW'(1));

   always_comb begin
      r0_in = q_r[QW-1:FRAC_BITS];
      a_in  = q_r[FRAC_BITS-1:0];
      c0_in = q_c[QW-1:FRAC_BITS];
      b_in  = q_c[FRAC_BITS-1:0];
      // The last output row or column pins to the last input pixel.
      if (dl_lr_ff[QW-1]) begin
         r0_in = nm1;
         a_in  = '0;
      end
      if (dl_lc_ff[QW-1]) begin
         c0_in = nm1;
         b_in  = '0;
      end
      if (r0_in > nm1) r0_in = nm1;
      if (c0_in > nm1) c0_in = nm1;
      r1_in = (NW'(r0_in) + NW'(1) < n_s) ? IW'(r0_in + 1'b1) : nm1;
      c1_in = (NW'(c0_in) + NW'(1) < n_s) ? IW'(c0_in + 1'b1) : nm1;
   end

   logic                 map_vld_ff, map_qry_ff, map_ld_ff;
   logic [IW-1:0]        map_r0_ff, map_r1_ff, map_c0_ff, map_c1_ff;
   logic [FRAC_BITS-1:0] map_a_ff, map_b_ff;
   logic [CW-1:0]        map_row_ff, map_col_ff;
   logic [PW-1:0]        map_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= 1'b0;
      end else if (en) begin
         map_vld_ff <= dl_vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         map_qry_ff <= dl_qry_ff[QW-1];
         map_ld_ff  <= dl_ld_ff[QW-1];
         map_r0_ff  <= r0_in;
         map_r1_ff  <= r1_in;
         map_c0_ff  <= c0_in;
         map_c1_ff  <= c1_in;
         map_a_ff   <= a_in;
         map_b_ff   <= b_in;
         map_row_ff <= dl_row_ff[QW-1];
         map_col_ff <= dl_col_ff[QW-1];
         map_pix_ff <= dl_pix_ff[QW-1];
      end
   end

   // ---------------- banked image store ----------------
   // Bank index is {row parity, col parity}. Rows r0 and r0+1 always cover
   // both parities, so each bank is read at the half-row that holds its row.
   logic [HW-1:0]   rh_even, rh_odd, ch_even, ch_odd;
   logic [AW-1:0]   rd_addr [4];
   logic [IW-1:0]   ld_row, ld_col;
   logic [1:0]      wr_bank;
   logic [AW-1:0]   wr_addr;
   logic            wr_en;
   logic [PW-1:0]   bank_mem [4][DEPTH];

   always_comb begin
      rh_even = HW'((map_r0_ff + 1'b1) >> 1);
      rh_odd  = HW'(map_r0_ff >> 1);
      ch_even = HW'((map_c0_ff + 1'b1) >> 1);
      ch_odd  = HW'(map_c0_ff >> 1);
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = {(b >= 2) ? rh_odd : rh_even, ((b % 2) == 1) ? ch_odd : ch_even};
      end
      ld_row  = IW'(map_row_ff);
      ld_col  = IW'(map_col_ff);
      wr_bank = {ld_row[0], ld_col[0]};
      wr_addr = {HW'(ld_row >> 1), HW'(ld_col >> 1)};
      wr_en   = map_vld_ff && map_ld_ff;
   end

   logic [PW-1:0] rd_pix_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int b = 0; b < 4; b++) begin
            if (wr_en && (wr_bank == 2'(b))) begin
               bank_mem[b][wr_addr] <= map_pix_ff;
            end
            rd_pix_ff[b] <= bank_mem[b][rd_addr[b]];
         end
      end
   end

   // ---------------- weight products, alongside the store read ----------------
   logic [WW-1:0] wa, wb;
   logic          rd_vld_ff, rd_qry_ff;
   logic          rd_r0p_ff, rd_r1p_ff, rd_c0p_ff, rd_c1p_ff;
   logic [CW-1:0] rd_row_ff, rd_col_ff;
   logic [W2-1:0] rd_w00_ff, rd_w01_ff, rd_w10_ff, rd_w11_ff;

   assign wa = (WW'(1) << FRAC_BITS) - WW'(map_a_ff);
   assign wb = (WW'(1) << FRAC_BITS) - WW'(map_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (en) begin
         rd_vld_ff <= map_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_qry_ff <= map_qry_ff;
         rd_r0p_ff <= map_r0_ff[0];
         rd_r1p_ff <= map_r1_ff[0];
         rd_c0p_ff <= map_c0_ff[0];
         rd_c1p_ff <= map_c1_ff[0];
         rd_row_ff <= map_row_ff;
         rd_col_ff <= map_col_ff;
         rd_w00_ff <= W2'(wa * wb);
         rd_w01_ff <= W2'(wa * WW'(map_b_ff));
         rd_w10_ff <= W2'(WW'(map_a_ff) * wb);
         rd_w11_ff <= W2'(WW'(map_a_ff) * WW'(map_b_ff));
      end
   end

   // ---------------- channel products ----------------
   logic [PW-1:0] p00, p01, p10, p11;

   assign p00 = rd_pix_ff[{rd_r0p_ff, rd_c0p_ff}];
   assign p01 = rd_pix_ff[{rd_r0p_ff, rd_c1p_ff}];
   assign p10 = rd_pix_ff[{rd_r1p_ff, rd_c0p_ff}];
   assign p11 = rd_pix_ff[{rd_r1p_ff, rd_c1p_ff}];

   logic          mul_vld_ff, mul_qry_ff;
   logic [CW-1:0] mul_row_ff, mul_col_ff;
   logic [MW-1:0] mul_ff [3][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (en) begin
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_qry_ff <= rd_qry_ff;
         mul_row_ff <= rd_row_ff;
         mul_col_ff <= rd_col_ff;
         for (int c = 0; c < 3; c++) begin
            mul_ff[c][0] <= MW'(rd_w00_ff) * MW'(p00[CHW*c +: CHW]);
            mul_ff[c][1] <= MW'(rd_w01_ff) * MW'(p01[CHW*c +: CHW]);
            mul_ff[c][2] <= MW'(rd_w10_ff) * MW'(p10[CHW*c +: CHW]);
            mul_ff[c][3] <= MW'(rd_w11_ff) * MW'(p11[CHW*c +: CHW]);
         end
      end
   end

   // ---------------- sum, round and output register ----------------
   logic [SW-1:0]  sum_s [3];
   logic [CHW-1:0] chan_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_s[c] = SW'(mul_ff[c][0]) + SW'(mul_ff[c][1]) + SW'(mul_ff[c][2])
                  + SW'(mul_ff[c][3]) + (SW'(1) << (2 * FRAC_BITS - 1));
         sum_s[c] = sum_s[c] >> (2 * FRAC_BITS);
         chan_in[c] = (sum_s[c] > SW'(255)) ? CHW'(255) : CHW'(sum_s[c]);
      end
   end

   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= mul_vld_ff && mul_qry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {4'd0, chan_in[0], chan_in[1], chan_in[2], mul_col_ff, mul_row_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the output register is stalled");

   a_next_row_adjacent: assert property (@(posedge clock) disable iff (reset)
      map_vld_ff && map_qry_ff |->
         (map_r1_ff == map_r0_ff) || (map_r1_ff == IW'(map_r0_ff + 1'b1)))
      else $error("second source row is not adjacent to the first");

   a_source_in_image: assert property (@(posedge clock) disable iff (reset)
      map_vld_ff && map_qry_ff |-> (NW'(map_r0_ff) < n_s) && (NW'(map_c0_ff) < n_s))
      else $error("source index lies outside the loaded image");

endmodule

`default_nettype wire

// ===== rtl/bir_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, one division accepted per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_div #(
   parameter int DVW = 28,
   parameter int DSW = 11,
   parameter int QW  = 17
) (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [DVW-1:0] dividend,
   input  wire logic [DSW-1:0] divisor,
   output logic      [QW-1:0]  quotient
);

   localparam int RW = (DVW > DSW + QW) ? DVW : DSW + QW;

   logic [RW-1:0] rem_ff [QW];
   logic [RW-1:0] rem_in [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [QW-1:0] q_in   [QW];

   // The caller guarantees the quotient fits in QW bits, so the first stage
   // may start at bit QW-1.
   always_comb begin
      logic [RW-1:0] src;
      logic [QW-1:0] qs;
      logic [RW-1:0] sh;
      for (int k = 0; k < QW; k++) begin
         src = (k == 0) ? RW'(dividend) : rem_ff[(k == 0) ? 0 : k-1];
         qs  = (k == 0) ? '0 : q_ff[(k == 0) ? 0 : k-1];
         sh  = RW'(divisor) << (QW - 1 - k);
         if (src >= sh) begin
            rem_in[k] = src - sh;
            q_in[k]   = {qs[QW-2:0], 1'b1};
         end else begin
            rem_in[k] = src;
            q_in[k]   = {qs[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign quotient = q_ff[QW-1];

endmodule

`default_nettype wire
